@@ hw/rtl/rtpa_pkg.sv @@
// Package: palette table, ramp table, widths and helpers for the palette cell.
package rtpa_pkg;

  localparam int NumColors = 16;
  localparam int IdxW      = 4;
  localparam int GlyphW    = 7;

  typedef logic [IdxW-1:0] idx_t;

  // Palette color, packed 0xRRGGBB.
  function automatic logic [23:0] pal_rgb(input logic [IdxW-1:0] i);
    logic [23:0] v;
    case (i)
      4'd0:    v = 24'h0C0C0C;
      4'd1:    v = 24'hC50F1F;
      4'd2:    v = 24'h13A1E0;
      4'd3:    v = 24'hC19C00;
      4'd4:    v = 24'h0037DA;
      4'd5:    v = 24'h881798;
      4'd6:    v = 24'h3A96DD;
      4'd7:    v = 24'hCCCCCC;
      4'd8:    v = 24'h767676;
      4'd9:    v = 24'hE74856;
      4'd10:   v = 24'h16C60C;
      4'd11:   v = 24'hF9F1A5;
      4'd12:   v = 24'h3B78FF;
      4'd13:   v = 24'hB4009E;
      4'd14:   v = 24'h61D6D6;
      default: v = 24'hF2F2F2;
    endcase
    return v;
  endfunction

  // Glyph ramp " .:-=+*#%@".
  function automatic logic [GlyphW-1:0] ramp_chr(input logic [3:0] q);
    logic [GlyphW-1:0] c;
    case (q)
      4'd0:    c = 7'd32;
      4'd1:    c = 7'd46;
      4'd2:    c = 7'd58;
      4'd3:    c = 7'd45;
      4'd4:    c = 7'd61;
      4'd5:    c = 7'd43;
      4'd6:    c = 7'd42;
      4'd7:    c = 7'd35;
      4'd8:    c = 7'd37;
      default: c = 7'd64;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/rgb_to_palette_ascii_cell.sv @@
// Top level: RGB pixel to palette text cell, a pipeline of registered stages.
//
// Takes one RGB word per cycle while the output is not stalled and returns
// one text-cell word per pixel, in order. There are fifteen register stages.
// A taken word moves through the stages in order into the output register,
// from which it leaves when the output takes it. Every stage advances
// together under one stall: when the output is held, the whole pipeline
// holds, so nothing is dropped and throughput is one word per cycle otherwise.
// Stages: (1) squared distance to all 16 palette colors; (2) nearest color by
// a 4-level compare tree; (3) difference vector d = P-N and per-candidate dot
// products; (4) squares of candidate distances and dot products; (5) cubes of
// candidate distances; (6) score products vs the 1e14 limit; (7..14) best
// candidate by a pairwise tree of cross products, two stages per level:
// 27-bit slices of one cube times the other side's squared dot product, then
// sum, compare and select; (15) glyph numerator/denominator, then ramp lookup
// by a compare against k*den for k = 1..9. No second color gives second color
// 0 and ' '.
module rgb_to_palette_ascii_cell (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // second_color[3:0], first_color[7:4],
                                     // glyph[14:8], zero[15]
);
  import rtpa_pkg::*;

  localparam int NSt = 15;
  localparam logic [47:0] LimSq = 48'd100000000000000;

  logic [NSt-1:0] vld_q;
  logic           adv;

  // Pipeline moves when the last stage is empty or being taken.
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NSt-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSt-2:0], s_axis_tvalid};
    end
  end

  // ---------------- stage 1: distances ----------------
  logic signed [9:0]  p1_q [3];
  logic        [17:0] dist1_q [NumColors];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        p1_q[c] <= signed'({2'b00, s_axis_tdata[c*8 +: 8]});
      end
      for (int i = 0; i < NumColors; i++) begin
        logic [23:0] pc;
        logic signed [9:0] e0, e1, e2;
        pc = pal_rgb(IdxW'(i));
        e0 = signed'({2'b00, s_axis_tdata[7:0]})   - signed'({2'b00, pc[23:16]});
        e1 = signed'({2'b00, s_axis_tdata[15:8]})  - signed'({2'b00, pc[15:8]});
        e2 = signed'({2'b00, s_axis_tdata[23:16]}) - signed'({2'b00, pc[7:0]});
        dist1_q[i] <= 18'(e0 * e0) + 18'(e1 * e1) + 18'(e2 * e2);
      end
    end
  end

  // ---------------- stage 2: nearest (4-level tree) ----------------
  logic signed [9:0] p2_q [3];
  idx_t              near2_q;
  logic [17:0]       bd2_q;

  // Left side holds the lower indices and wins ties.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [17:0] td [NumColors];
      idx_t        ti [NumColors];
      for (int i = 0; i < NumColors; i++) begin
        td[i] = dist1_q[i];
        ti[i] = IdxW'(i);
      end
      for (int half = NumColors >> 1; half >= 1; half = half >> 1) begin
        for (int i = 0; i < half; i++) begin
          if (td[2*i+1] < td[2*i]) begin
            td[i] = td[2*i+1];
            ti[i] = ti[2*i+1];
          end else begin
            td[i] = td[2*i];
            ti[i] = ti[2*i];
          end
        end
      end
      p2_q    <= p1_q;
      near2_q <= ti[0];
      bd2_q   <= td[0];
    end
  end

  // ---------------- stage 3: d and per-candidate s, pr ----------------
  logic signed [9:0]  d3_q [3];
  idx_t               near3_q;
  logic [17:0]        dn3_q;
  logic [17:0]        s3_q  [NumColors];
  logic [17:0]        pr3_q [NumColors];
  logic [NumColors-1:0] ok3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [23:0] pn, pc;
      logic signed [9:0] d [3];
      logic signed [9:0] v [3];
      logic signed [20:0] pr;
      pn = pal_rgb(near2_q);
      d[0] = p2_q[0] - signed'({2'b00, pn[23:16]});
      d[1] = p2_q[1] - signed'({2'b00, pn[15:8]});
      d[2] = p2_q[2] - signed'({2'b00, pn[7:0]});
      for (int i = 0; i < NumColors; i++) begin
        pc = pal_rgb(IdxW'(i));
        v[0] = signed'({2'b00, pc[23:16]}) - p2_q[0];
        v[1] = signed'({2'b00, pc[15:8]})  - p2_q[1];
        v[2] = signed'({2'b00, pc[7:0]})   - p2_q[2];
        pr = 21'(v[0] * d[0]) + 21'(v[1] * d[1]) + 21'(v[2] * d[2]);
        s3_q[i]  <= 18'(v[0] * v[0]) + 18'(v[1] * v[1]) + 18'(v[2] * v[2]);
        pr3_q[i] <= pr[17:0];
        ok3_q[i] <= (pr > 0) && (bd2_q != '0);
      end
      d3_q    <= d;
      near3_q <= near2_q;
      dn3_q   <= bd2_q;
    end
  end

  // ---------------- stage 4: s^2, pr^2 ----------------
  logic signed [9:0]  d4_q [3];
  idx_t               near4_q;
  logic [17:0]        dn4_q;
  logic [17:0]        s4_q   [NumColors];
  logic [35:0]        sq4_q  [NumColors];
  logic [35:0]        pr24_q [NumColors];
  logic [NumColors-1:0] ok4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NumColors; i++) begin
        s4_q[i]   <= s3_q[i];
        sq4_q[i]  <= 36'(s3_q[i]) * 36'(s3_q[i]);
        pr24_q[i] <= 36'(pr3_q[i]) * 36'(pr3_q[i]);
        ok4_q[i]  <= ok3_q[i] && (s3_q[i] != '0);
      end
      d4_q <= d3_q; near4_q <= near3_q; dn4_q <= dn3_q;
    end
  end

  // ---------------- stage 5: cube ----------------
  logic signed [9:0]  d5_q [3];
  idx_t               near5_q;
  logic [17:0]        dn5_q;
  logic [53:0]        cub5_q [NumColors];
  logic [35:0]        pr25_q [NumColors];
  logic [NumColors-1:0] ok5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NumColors; i++) begin
        cub5_q[i] <= 54'(sq4_q[i]) * 54'(s4_q[i]);
      end
      pr25_q <= pr24_q; ok5_q <= ok4_q;
      d5_q <= d4_q; near5_q <= near4_q; dn5_q <= dn4_q;
    end
  end

  // ---------------- stage 6: limit check ----------------
  logic signed [9:0]  d6_q [3];
  idx_t               near6_q;
  logic [53:0]        cub6_q [NumColors];
  logic [35:0]        pr26_q [NumColors];
  logic [NumColors-1:0] ok6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NumColors; i++) begin
        ok6_q[i] <= ok5_q[i] &&
                    ((72'(cub5_q[i]) * 72'(dn5_q)) < (84'(LimSq) * 84'(pr25_q[i])));
      end
      cub6_q <= cub5_q; pr26_q <= pr25_q;
      d6_q <= d5_q; near6_q <= near5_q;
    end
  end

  // ---------------- stages 7..14: best candidate tree ----------------
  // Heap order: node n has children 2n+1 and 2n+2; children 15..30 are the
  // sixteen candidates. Right child wins only when strictly better, so ties
  // keep the lower index.
  localparam int NNode  = NumColors - 1;
  localparam int NKid   = 2 * NumColors - 2;
  localparam int HalfW  = 27;
  localparam int TreeSt = 8;

  logic [53:0]       ac_q [1:NKid];
  logic [35:0]       ap_q [1:NKid];
  logic [NKid:1]     ao_q;
  idx_t              ai_q [1:NKid];
  logic [62:0]       lh_q [NNode];
  logic [62:0]       ll_q [NNode];
  logic [62:0]       rh_q [NNode];
  logic [62:0]       rl_q [NNode];
  logic [53:0]       tc_q [1:NNode-1];
  logic [35:0]       tp_q [1:NNode-1];
  logic [NNode-1:0]  to_q;
  idx_t              ti_q [NNode];
  logic signed [9:0] dt_q [TreeSt][3];
  idx_t              nt_q [TreeSt];

  // First stage of a level: copy both children, cross partial products.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [53:0] kc [1:NKid];
      logic [35:0] kp [1:NKid];
      for (int c = 1; c < NNode; c++) begin
        kc[c]   = tc_q[c];
        kp[c]   = tp_q[c];
        ao_q[c] <= to_q[c];
        ai_q[c] <= ti_q[c];
      end
      for (int i = 0; i < NumColors; i++) begin
        kc[NNode+i]   = cub6_q[i];
        kp[NNode+i]   = pr26_q[i];
        ao_q[NNode+i] <= ok6_q[i];
        ai_q[NNode+i] <= IdxW'(i);
      end
      for (int c = 1; c <= NKid; c++) begin
        ac_q[c] <= kc[c];
        ap_q[c] <= kp[c];
      end
      // right cube * left pr^2 against left cube * right pr^2
      for (int n = 0; n < NNode; n++) begin
        lh_q[n] <= 63'(kc[2*n+2][53:HalfW])   * 63'(kp[2*n+1]);
        ll_q[n] <= 63'(kc[2*n+2][HalfW-1:0])  * 63'(kp[2*n+1]);
        rh_q[n] <= 63'(kc[2*n+1][53:HalfW])   * 63'(kp[2*n+2]);
        rl_q[n] <= 63'(kc[2*n+1][HalfW-1:0])  * 63'(kp[2*n+2]);
      end
      dt_q[0] <= d6_q;
      nt_q[0] <= near6_q;
      for (int k = 1; k < TreeSt; k++) begin
        dt_q[k] <= dt_q[k-1];
        nt_q[k] <= nt_q[k-1];
      end
    end
  end

  // Second stage of a level: sum slices, compare, keep the winner.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [NNode-1:0] sel;
      for (int n = 0; n < NNode; n++) begin
        sel[n] = ao_q[2*n+2] && (!ao_q[2*n+1] ||
                 (((90'(lh_q[n]) << HalfW) + 90'(ll_q[n])) <
                  ((90'(rh_q[n]) << HalfW) + 90'(rl_q[n]))));
        to_q[n] <= ao_q[2*n+1] || ao_q[2*n+2];
        ti_q[n] <= sel[n] ? ai_q[2*n+2] : ai_q[2*n+1];
      end
      for (int n = 1; n < NNode; n++) begin
        tc_q[n] <= sel[n] ? ac_q[2*n+2] : ac_q[2*n+1];
        tp_q[n] <= sel[n] ? ap_q[2*n+2] : ap_q[2*n+1];
      end
    end
  end

  // ---------------- stage 15: glyph ----------------
  logic [15:0] out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [23:0] pn, po;
      logic signed [9:0]  w [3];
      logic signed [9:0]  dd [3];
      logic signed [31:0] num, den;
      logic [3:0]         q;
      dd = dt_q[TreeSt-1];
      pn = pal_rgb(nt_q[TreeSt-1]);
      po = pal_rgb(ti_q[0]);
      w[0] = signed'({2'b00, po[23:16]}) - signed'({2'b00, pn[23:16]});
      w[1] = signed'({2'b00, po[15:8]})  - signed'({2'b00, pn[15:8]});
      w[2] = signed'({2'b00, po[7:0]})   - signed'({2'b00, pn[7:0]});
      num = 32'sd1099 * (32'(w[0] * dd[0]) + 32'(w[1] * dd[1]) + 32'(w[2] * dd[2]));
      den = 32'sd50 * (32'(w[0] * w[0]) + 32'(w[1] * w[1]) + 32'(w[2] * w[2]));
      q = '0;
      if (num > 0 && den > 0) begin
        for (int k = 1; k <= 9; k++) begin
          if (num >= 32'(k) * den) q = 4'(k);
        end
      end
      if (to_q[0]) begin
        out_q <= {1'b0, ramp_chr(q), nt_q[TreeSt-1], ti_q[0]};
      end else begin
        out_q <= {1'b0, ramp_chr(4'd0), nt_q[TreeSt-1], idx_t'(0)};
      end
    end
  end

  assign m_axis_tdata = out_q;

endmodule
